// File: sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define AST_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked on every clock outside reset.
`define AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: sv/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg
// Token kinds, error codes, result types and character classes of the tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

    localparam logic [1:0] E_NONE    = 2'd0;
    localparam logic [1:0] E_BADCHAR = 2'd1;
    localparam logic [1:0] E_OPENSTR = 2'd2;

    localparam logic [5:0] K_EOF      = 6'd0;
    localparam logic [5:0] K_IDENT    = 6'd1;
    localparam logic [5:0] K_INT      = 6'd2;
    localparam logic [5:0] K_FLOAT    = 6'd3;
    localparam logic [5:0] K_STR      = 6'd4;
    localparam logic [5:0] K_KW_FIRST = 6'd5;
    localparam logic [5:0] K_LPAREN   = 6'd14;
    localparam logic [5:0] K_RPAREN   = 6'd15;
    localparam logic [5:0] K_LBRACK   = 6'd16;
    localparam logic [5:0] K_RBRACK   = 6'd17;
    localparam logic [5:0] K_LBRACE   = 6'd18;
    localparam logic [5:0] K_RBRACE   = 6'd19;
    localparam logic [5:0] K_INC      = 6'd20;
    localparam logic [5:0] K_ADDEQ    = 6'd21;
    localparam logic [5:0] K_ADD      = 6'd22;
    localparam logic [5:0] K_DEC      = 6'd23;
    localparam logic [5:0] K_SUBEQ    = 6'd24;
    localparam logic [5:0] K_ARROW    = 6'd25;
    localparam logic [5:0] K_SUB      = 6'd26;
    localparam logic [5:0] K_POWEQ    = 6'd27;
    localparam logic [5:0] K_POW      = 6'd28;
    localparam logic [5:0] K_MULEQ    = 6'd29;
    localparam logic [5:0] K_MUL      = 6'd30;
    localparam logic [5:0] K_IDIVEQ   = 6'd31;
    localparam logic [5:0] K_IDIV     = 6'd32;
    localparam logic [5:0] K_DIVEQ    = 6'd33;
    localparam logic [5:0] K_DIV      = 6'd34;
    localparam logic [5:0] K_MODEQ    = 6'd35;
    localparam logic [5:0] K_MOD      = 6'd36;
    localparam logic [5:0] K_NE       = 6'd37;
    localparam logic [5:0] K_NOT      = 6'd38;
    localparam logic [5:0] K_LE       = 6'd39;
    localparam logic [5:0] K_LT       = 6'd40;
    localparam logic [5:0] K_GE       = 6'd41;
    localparam logic [5:0] K_GT       = 6'd42;
    localparam logic [5:0] K_EQ       = 6'd43;
    localparam logic [5:0] K_ASSIGN   = 6'd44;
    localparam logic [5:0] K_OROR     = 6'd45;
    localparam logic [5:0] K_OR       = 6'd46;
    localparam logic [5:0] K_ANDAND   = 6'd47;
    localparam logic [5:0] K_AND      = 6'd48;
    localparam logic [5:0] K_DOT      = 6'd49;
    localparam logic [5:0] K_COMMA    = 6'd50;
    localparam logic [5:0] K_COLON    = 6'd51;
    localparam logic [5:0] K_SEMI     = 6'd52;
    localparam logic [5:0] K_QUEST    = 6'd53;

    localparam int KW_COUNT = 9;
    // Keyword text, first character in the lowest byte, zero padded.
    localparam logic [39:0] KW_TEXT [KW_COUNT] = '{
        40'h000074656C, 40'h000074756D, 40'h00006E7566, 40'h0065707974,
        40'h0000006669, 40'h0065736C65,
        40'h0000726F66, 40'h0000006E69, 40'h656C696877
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd3, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd2, 3'd5
    };

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef struct packed {
        logic [1:0]  err;
        logic [5:0]  kind;
        logic [31:0] off;
        logic [31:0] len;
        logic [15:0] line;
        logic [15:0] col;
    } t_res;

    // All results caused by one input beat.
    typedef struct packed {
        t_res [2:0] res;
        logic [1:0] cnt;
    } t_bundle;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic [5:0] kw_kind(input logic [39:0] prefix, input logic [2:0] len);
        logic [5:0] k;
        k = K_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (len == KW_LEN[i] && prefix == KW_TEXT[i]) k = K_KW_FIRST + 6'(i);
        end
        return k;
    endfunction

    function automatic logic [5:0] single_kind(input logic [7:0] b);
        case (b)
            "(":     return K_LPAREN;
            ")":     return K_RPAREN;
            "[":     return K_LBRACK;
            "]":     return K_RBRACK;
            "{":     return K_LBRACE;
            "}":     return K_RBRACE;
            ".":     return K_DOT;
            ",":     return K_COMMA;
            ":":     return K_COLON;
            ";":     return K_SEMI;
            "?":     return K_QUEST;
            default: return K_EOF;
        endcase
    endfunction

    function automatic logic [5:0] op_start_kind(input logic [7:0] b);
        case (b)
            "+":     return K_ADD;
            "-":     return K_SUB;
            "*":     return K_MUL;
            "/":     return K_DIV;
            "%":     return K_MOD;
            "!":     return K_NOT;
            "<":     return K_LT;
            ">":     return K_GT;
            "=":     return K_ASSIGN;
            "|":     return K_OR;
            "&":     return K_AND;
            default: return K_EOF;
        endcase
    endfunction

    // Kind after appending b to a pending operator, K_EOF if it cannot grow.
    function automatic logic [5:0] op_extend(input logic [5:0] k, input logic [7:0] b);
        case (k)
            K_ADD:   return b == "+" ? K_INC : b == "=" ? K_ADDEQ : K_EOF;
            K_SUB:   return b == "-" ? K_DEC : b == "=" ? K_SUBEQ : b == ">" ? K_ARROW : K_EOF;
            K_MUL:   return b == "*" ? K_POW : b == "=" ? K_MULEQ : K_EOF;
            K_POW:   return b == "=" ? K_POWEQ : K_EOF;
            K_DIV:   return b == "/" ? K_IDIV : b == "=" ? K_DIVEQ : K_EOF;
            K_IDIV:  return b == "=" ? K_IDIVEQ : K_EOF;
            K_MOD, K_NOT, K_LT, K_GT, K_ASSIGN:
                     return b == "=" ? k - 6'd1 : K_EOF;
            K_OR:    return b == "|" ? K_OROR : K_EOF;
            K_AND:   return b == "&" ? K_ANDAND : K_EOF;
            default: return K_EOF;
        endcase
    endfunction

endpackage

// File: sv/stt_front.sv
// ----------------------------------------------------------------------------
// stt_front
// Scanner: takes one text byte per beat and builds the results it causes.
// ----------------------------------------------------------------------------
module stt_front #(
    parameter int OFFSET_BITS = 32,
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  logic             i_end,
    input  logic             i_full,
    output logic             o_ready,
    output logic             o_push,
    output stt_pkg::t_bundle o_bundle
);
    import stt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_IDENT, S_INT, S_INTDOT, S_FLOAT, S_STR, S_OP, S_DONE
    } t_mode;

    localparam logic [OFFSET_BITS-1:0] ONE_OFF = OFFSET_BITS'(1);
    localparam logic [LINE_BITS-1:0]   LMAX    = '1;
    localparam logic [COLUMN_BITS-1:0] CMAX    = '1;
    localparam logic [COLUMN_BITS-1:0] CMAX_M1 = CMAX - COLUMN_BITS'(1);

    t_mode                  r_mode, n_mode;
    logic [5:0]             r_pend, n_pend;
    logic [OFFSET_BITS-1:0] r_start_off, n_start_off;
    logic [LINE_BITS-1:0]   r_start_line, n_start_line;
    logic [COLUMN_BITS-1:0] r_start_col, n_start_col;
    logic [OFFSET_BITS-1:0] r_cur_off, n_cur_off;
    logic [LINE_BITS-1:0]   r_cur_line, n_cur_line;
    logic [COLUMN_BITS-1:0] r_cur_col, n_cur_col;
    logic [39:0]            r_prefix, n_prefix;
    logic [OFFSET_BITS-1:0] r_len, n_len;
    logic [OFFSET_BITS-1:0] r_dot_off, n_dot_off;
    logic [LINE_BITS-1:0]   r_dot_line, n_dot_line;
    logic [COLUMN_BITS-1:0] r_dot_col, n_dot_col;

    t_res       res [3];
    logic [1:0] cnt;
    logic       accept, is_end, consumed;
    logic [7:0] b;
    logic [5:0] ext, sk, ok;
    logic [2:0] len3;

    function automatic logic [31:0] w32(input logic [OFFSET_BITS-1:0] v);
        logic [63:0] e;
        e = 64'(v);
        return e[31:0];
    endfunction

    function automatic logic [15:0] sat_line(input logic [LINE_BITS-1:0] v);
        logic [31:0] e;
        e = 32'(v);
        return (e > 32'd65535) ? 16'hFFFF : e[15:0];
    endfunction

    function automatic logic [15:0] sat_col(input logic [COLUMN_BITS-1:0] v);
        logic [31:0] e;
        e = 32'(v);
        return (e > 32'd65535) ? 16'hFFFF : e[15:0];
    endfunction

    function automatic t_res mk(input logic [1:0] err, input logic [5:0] kind,
                                input logic [OFFSET_BITS-1:0] off,
                                input logic [OFFSET_BITS-1:0] len,
                                input logic [LINE_BITS-1:0] line,
                                input logic [COLUMN_BITS-1:0] col);
        t_res r;
        r.err  = err;
        r.kind = kind;
        r.off  = w32(off);
        r.len  = w32(len);
        r.line = sat_line(line);
        r.col  = sat_col(col);
        return r;
    endfunction

    assign accept  = i_valid && !i_full;
    assign o_ready = !i_full;
    assign b       = i_byte;
    assign is_end  = i_end || (b == 8'd0);
    assign ext     = op_extend(r_pend, b);
    assign sk      = single_kind(b);
    assign ok      = op_start_kind(b);
    assign len3    = (r_len < OFFSET_BITS'(8)) ? r_len[2:0] : 3'd7;

    always_comb begin
        n_mode       = r_mode;
        n_pend       = r_pend;
        n_start_off  = r_start_off;
        n_start_line = r_start_line;
        n_start_col  = r_start_col;
        n_cur_off    = r_cur_off;
        n_cur_line   = r_cur_line;
        n_cur_col    = r_cur_col;
        n_prefix     = r_prefix;
        n_len        = r_len;
        n_dot_off    = r_dot_off;
        n_dot_line   = r_dot_line;
        n_dot_col    = r_dot_col;
        res          = '{default: '0};
        cnt          = 2'd0;
        consumed     = 1'b0;

        if (accept && r_mode != S_DONE) begin
            if (is_end) begin
                unique case (r_mode)
                    S_IDENT: begin
                        res[cnt] = mk(E_NONE, kw_kind(r_prefix, len3), r_start_off, r_len,
                                      r_start_line, r_start_col);
                        cnt = cnt + 2'd1;
                    end
                    S_INT, S_FLOAT: begin
                        res[cnt] = mk(E_NONE, (r_mode == S_INT) ? K_INT : K_FLOAT,
                                      r_start_off, r_len, r_start_line, r_start_col);
                        cnt = cnt + 2'd1;
                    end
                    S_INTDOT: begin
                        res[cnt] = mk(E_NONE, K_INT, r_start_off, r_len - ONE_OFF,
                                      r_start_line, r_start_col);
                        cnt = cnt + 2'd1;
                        res[cnt] = mk(E_NONE, K_DOT, r_dot_off, ONE_OFF, r_dot_line, r_dot_col);
                        cnt = cnt + 2'd1;
                    end
                    S_STR: begin
                        res[cnt] = mk(E_OPENSTR, K_EOF, r_start_off, ONE_OFF,
                                      r_start_line, r_start_col);
                        cnt = cnt + 2'd1;
                    end
                    S_OP: begin
                        res[cnt] = mk(E_NONE, r_pend, r_start_off, r_len,
                                      r_start_line, r_start_col);
                        cnt = cnt + 2'd1;
                    end
                    default: ;
                endcase
                res[cnt] = mk(E_NONE, K_EOF, r_cur_off, ONE_OFF, r_cur_line, r_cur_col);
                cnt = cnt + 2'd1;
                n_mode = S_DONE;
            end else begin
                n_len = r_len + ONE_OFF;
                unique case (r_mode)
                    S_IDENT: begin
                        if (is_alpha(b) || is_digit(b) || b == "_") begin
                            consumed = 1'b1;
                            if (r_len < OFFSET_BITS'(5))
                                n_prefix = r_prefix | (40'(b) << {r_len[2:0], 3'b000});
                        end else begin
                            res[cnt] = mk(E_NONE, kw_kind(r_prefix, len3), r_start_off, r_len,
                                          r_start_line, r_start_col);
                            cnt = cnt + 2'd1;
                        end
                    end
                    S_INT: begin
                        if (is_digit(b) || b == "_") begin
                            consumed = 1'b1;
                        end else if (b == ".") begin
                            consumed   = 1'b1;
                            n_mode     = S_INTDOT;
                            n_dot_off  = r_cur_off;
                            n_dot_line = r_cur_line;
                            // A dot on the last column but one is reported saturated.
                            n_dot_col  = (r_cur_col >= CMAX_M1) ? CMAX : r_cur_col;
                        end else begin
                            res[cnt] = mk(E_NONE, K_INT, r_start_off, r_len,
                                          r_start_line, r_start_col);
                            cnt = cnt + 2'd1;
                        end
                    end
                    S_INTDOT: begin
                        if (is_digit(b)) begin
                            consumed = 1'b1;
                            n_mode   = S_FLOAT;
                        end else begin
                            res[cnt] = mk(E_NONE, K_INT, r_start_off, r_len - ONE_OFF,
                                          r_start_line, r_start_col);
                            cnt = cnt + 2'd1;
                            res[cnt] = mk(E_NONE, K_DOT, r_dot_off, ONE_OFF,
                                          r_dot_line, r_dot_col);
                            cnt = cnt + 2'd1;
                        end
                    end
                    S_FLOAT: begin
                        if (is_digit(b) || b == "_") begin
                            consumed = 1'b1;
                        end else begin
                            res[cnt] = mk(E_NONE, K_FLOAT, r_start_off, r_len,
                                          r_start_line, r_start_col);
                            cnt = cnt + 2'd1;
                            if (b == ".") begin
                                // A second dot becomes a token of its own.
                                consumed = 1'b1;
                                n_mode   = S_IDLE;
                                res[cnt] = mk(E_NONE, K_DOT, r_cur_off, ONE_OFF,
                                              r_cur_line, r_cur_col);
                                cnt = cnt + 2'd1;
                            end
                        end
                    end
                    S_STR: begin
                        consumed = 1'b1;
                        if (b == "\"") begin
                            res[cnt] = mk(E_NONE, K_STR, r_start_off, r_len + ONE_OFF,
                                          r_start_line, r_start_col);
                            cnt = cnt + 2'd1;
                            n_mode = S_IDLE;
                        end
                    end
                    S_OP: begin
                        if (ext != K_EOF) begin
                            consumed = 1'b1;
                            if (ext == K_POW || ext == K_IDIV) begin
                                n_pend = ext;
                            end else begin
                                res[cnt] = mk(E_NONE, ext, r_start_off, r_len + ONE_OFF,
                                              r_start_line, r_start_col);
                                cnt = cnt + 2'd1;
                                n_mode = S_IDLE;
                            end
                        end else begin
                            res[cnt] = mk(E_NONE, r_pend, r_start_off, r_len,
                                          r_start_line, r_start_col);
                            cnt = cnt + 2'd1;
                        end
                    end
                    default: ;
                endcase

                // The byte that ended a token is scanned again as a fresh start.
                if (!consumed) begin
                    n_mode = S_IDLE;
                    if (b == " " || b == 8'h09 || b == 8'h0D || b == 8'h0A) begin
                        n_mode = S_IDLE;
                    end else if (is_alpha(b) || is_digit(b) || b == "_" || b == "\""
                                 || ok != K_EOF) begin
                        n_start_off  = r_cur_off;
                        n_start_line = r_cur_line;
                        n_start_col  = r_cur_col;
                        n_len        = ONE_OFF;
                        if (is_alpha(b) || b == "_") begin
                            n_mode   = S_IDENT;
                            n_prefix = 40'(b);
                        end else if (is_digit(b)) begin
                            n_mode = S_INT;
                        end else if (b == "\"") begin
                            n_mode = S_STR;
                        end else begin
                            n_mode = S_OP;
                            n_pend = ok;
                        end
                    end else if (sk != K_EOF) begin
                        res[cnt] = mk(E_NONE, sk, r_cur_off, ONE_OFF, r_cur_line, r_cur_col);
                        cnt = cnt + 2'd1;
                    end else begin
                        res[cnt] = mk(E_BADCHAR, K_EOF, r_cur_off, ONE_OFF,
                                      r_cur_line, r_cur_col);
                        cnt = cnt + 2'd1;
                    end
                end

                n_cur_off = r_cur_off + ONE_OFF;
                if (b == 8'h0A) begin
                    if (r_cur_line != LMAX) n_cur_line = r_cur_line + LINE_BITS'(1);
                    n_cur_col = COLUMN_BITS'(1);
                end else if (r_cur_col != CMAX) begin
                    n_cur_col = r_cur_col + COLUMN_BITS'(1);
                end
            end
        end
    end

    assign o_push       = cnt != 2'd0;
    assign o_bundle.cnt = cnt;
    assign o_bundle.res = {res[2], res[1], res[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= S_IDLE;
            r_pend       <= K_EOF;
            r_start_off  <= '0;
            r_start_line <= LINE_BITS'(1);
            r_start_col  <= COLUMN_BITS'(1);
            r_cur_off    <= '0;
            r_cur_line   <= LINE_BITS'(1);
            r_cur_col    <= COLUMN_BITS'(1);
            r_prefix     <= '0;
            r_len        <= '0;
            r_dot_off    <= '0;
            r_dot_line   <= LINE_BITS'(1);
            r_dot_col    <= COLUMN_BITS'(1);
        end else begin
            r_mode       <= n_mode;
            r_pend       <= n_pend;
            r_start_off  <= n_start_off;
            r_start_line <= n_start_line;
            r_start_col  <= n_start_col;
            r_cur_off    <= n_cur_off;
            r_cur_line   <= n_cur_line;
            r_cur_col    <= n_cur_col;
            r_prefix     <= n_prefix;
            r_len        <= n_len;
            r_dot_off    <= n_dot_off;
            r_dot_line   <= n_dot_line;
            r_dot_col    <= n_dot_col;
        end
    end

endmodule

// File: sv/stt_queue.sv
// ----------------------------------------------------------------------------
// stt_queue
// Short queue of result bundles between the scanner and the output stage.
// ----------------------------------------------------------------------------
module stt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  stt_pkg::t_bundle i_bundle,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_nonempty,
    output stt_pkg::t_bundle o_head
);
    import stt_pkg::*;

    t_bundle         r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_AW:0]   r_cnt;

    assign o_full     = r_cnt == (Q_AW + 1)'(Q_DEPTH);
    assign o_nonempty = r_cnt != '0;
    assign o_head     = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (Q_AW + 1)'(i_push) - (Q_AW + 1)'(i_pop);
        end
    end

endmodule

// File: sv/stt_back.sv
// ----------------------------------------------------------------------------
// stt_back
// Output stage: walks through each bundle and sends one result per beat.
// ----------------------------------------------------------------------------
module stt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_nonempty,
    input  stt_pkg::t_bundle i_head,
    output logic             o_pop,
    input  logic             i_m_ready,
    output logic             o_m_valid,
    output stt_pkg::t_res    o_m_res,
    output logic             o_m_last
);
    import stt_pkg::*;

    logic       r_valid, r_last;
    t_res       r_res;
    logic [1:0] r_idx;
    logic       load, last;

    assign load      = i_nonempty && (!r_valid || i_m_ready);
    assign last      = r_idx == (i_head.cnt - 2'd1);
    assign o_pop     = load && last;
    assign o_m_valid = r_valid;
    assign o_m_res   = r_res;
    assign o_m_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_res   <= i_head.res[r_idx];
            r_last  <= last;
            r_idx   <= last ? 2'd0 : r_idx + 2'd1;
        end else if (i_m_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// File: sv/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Maximal-munch lexer: bytes in, tokens with position out.
// ----------------------------------------------------------------------------
// The tokenizer takes one source byte per beat while the queue is not full; the
// scanner decodes a beat in the cycle it is accepted and writes its results into
// the queue at that edge, and the output register then loads from the queue, so
// the first result passes through the queue and the output register.
// A beat may cause up to three results, which leave at one per cycle while the
// output port is ready, so the output port sets the sustained rate when results
// bunch up; the four-entry bundle queue absorbs short bursts before input stalls.
module source_text_tokenizer #(
    parameter int OFFSET_BITS = 32,
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,  // text_byte
    input  logic [0:0]  i_s_tuser,  // end_mark
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [95:0] o_m_tdata,  // start_offset, token_length, line_number, column_number
    output logic [7:0]  o_m_tuser,  // error_code, token_kind
    output logic        o_m_tlast   // last_of_run
);
    import stt_pkg::*;

    logic    full, push, pop, nonempty;
    t_bundle bundle, head;
    t_res    res;

    stt_front #(
        .OFFSET_BITS(OFFSET_BITS),
        .LINE_BITS  (LINE_BITS),
        .COLUMN_BITS(COLUMN_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_byte  (i_s_tdata),
        .i_end   (i_s_tuser[0]),
        .i_full  (full),
        .o_ready (o_s_tready),
        .o_push  (push),
        .o_bundle(bundle)
    );

    stt_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_bundle  (bundle),
        .i_pop     (pop),
        .o_full    (full),
        .o_nonempty(nonempty),
        .o_head    (head)
    );

    stt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_nonempty(nonempty),
        .i_head    (head),
        .o_pop     (pop),
        .i_m_ready (i_m_tready),
        .o_m_valid (o_m_tvalid),
        .o_m_res   (res),
        .o_m_last  (o_m_tlast)
    );

    assign o_m_tdata = {res.col, res.line, res.len, res.off};
    assign o_m_tuser = {res.kind, res.err};

endmodule

// File: sv/stt_checker.sv
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks of the tokenizer's result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [95:0] o_m_tdata,
    input logic [7:0]  o_m_tuser,
    input logic        o_m_tlast
);

    `AST_NEXT(a_hold_valid, o_m_tvalid && !i_m_tready, o_m_tvalid)
    `AST_NEXT(a_hold_data, o_m_tvalid && !i_m_tready, $stable(o_m_tdata) && $stable(o_m_tuser))
    `AST_IMPLY(a_err_shape, o_m_tvalid && o_m_tuser[1:0] != 2'd0, o_m_tuser[7:2] == 6'd0 && o_m_tdata[63:32] == 32'd1 && o_m_tuser[1:0] != 2'd3)
    `AST_IMPLY(a_eof_last, o_m_tvalid && o_m_tuser == 8'd0, o_m_tlast && o_m_tdata[63:32] == 32'd1)

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (.*);
